/* src/pat_pkg.sv */
// ----------------------------------------------------------------------------
// pat_pkg: shared types and constants for the paged address translator
// Holds the control state encoding, register indexes and stream field layout.
// ----------------------------------------------------------------------------
`default_nettype none

package pat_pkg;

  // Field widths
  localparam int unsigned PAGE_SIZE_W  = 16;
  localparam int unsigned PAGE_COUNT_W = 7;
  localparam int unsigned INDEX_W      = 6;
  localparam int unsigned FRAME_W      = 16;
  localparam int unsigned ADDR_W       = 32;

  // Stream payload widths (byte aligned)
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 32;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PAGE_SIZE  = 1'b0,
    REG_PAGE_COUNT = 1'b1
  } reg_index_t;

  // Item kinds carried on s_tuser
  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // Result status carried on m_tuser
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_FAULT = 1'b1;

  // Translation sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_OUT
  } state_t;

  // Divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* src/pat_ram.sv */
// ----------------------------------------------------------------------------
// pat_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/pat_div.sv */
// ----------------------------------------------------------------------------
// pat_div: restoring radix-2 divider, 32-bit dividend by 16-bit divisor
// One quotient bit per cycle; results hold until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [pat_pkg::ADDR_W-1:0]          dividend,
  input  wire logic [pat_pkg::PAGE_SIZE_W-1:0]     divisor,
  output pat_pkg::div_stat_t                       stat,
  output logic      [pat_pkg::ADDR_W-1:0]          quotient,
  output logic      [pat_pkg::PAGE_SIZE_W-1:0]     remainder
);

  localparam int unsigned CNT_W = $clog2(pat_pkg::ADDR_W);

  logic                              busy;
  logic                              done;
  logic [CNT_W-1:0]                  cnt;
  logic [pat_pkg::PAGE_SIZE_W-1:0]   dsr;
  logic [pat_pkg::PAGE_SIZE_W:0]     shifted;
  logic [pat_pkg::PAGE_SIZE_W+1:0]   diff;
  logic                              qbit;

  // Trial subtraction of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {remainder, quotient[pat_pkg::ADDR_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr};
    qbit    = ~diff[pat_pkg::PAGE_SIZE_W+1];
  end

  // Control: busy while the quotient bits are produced, then a done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(pat_pkg::ADDR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient register doubles as the dividend shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient <= {quotient[pat_pkg::ADDR_W-2:0], qbit};
      if (qbit) begin
        remainder <= diff[pat_pkg::PAGE_SIZE_W-1:0];
      end else begin
        remainder <= shifted[pat_pkg::PAGE_SIZE_W-1:0];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

/* src/paged_address_translation.sv */
// ----------------------------------------------------------------------------
// paged_address_translation: single-level page table address translator
// Splits a logical address by the page size and maps the page to a frame.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream. s_tuser selects the kind: a load
//   request writes frame_number into table entry entry_index and gives no
//   response; a translate request gives one response on the m_* stream.
//   page_size and page_count are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while the block is idle; the block has no check for this.
//   A load leaves the block idle, so the next request is accepted right after.
//   A translate request passes through the bit-serial divider (one quotient
//   bit per cycle), the page table read, the frame multiply and the offset
//   add before its response is registered on m_*. A page beyond the page
//   count faults straight after the divider, a zero page size with no
//   division.
//   The block works on one translate request at a time; s_tready is high
//   again once the response sits in the output register.
//   If the receiver stalls, the response holds on m_*, the next request is
//   still accepted, and its result waits until the output register frees.
//   Reset clears control state and sets page_size to 4096 and page_count to
//   64. The table contents are undefined until each entry is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_address_translation #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Request stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // s_tdata: entry_index[5:0], frame_number[21:6], logical_address[53:22]
  input  wire logic [pat_pkg::S_TDATA_W-1:0]     s_tdata,
  // s_tuser: op[0]
  input  wire logic [0:0]                        s_tuser,
  // Response stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // m_tdata: physical_address[31:0]
  output logic      [pat_pkg::M_TDATA_W-1:0]     m_tdata,
  // m_tuser: status[0]
  output logic      [0:0]                        m_tuser,
  // Configuration
  input  wire logic                              cfg_we,
  input  wire logic [pat_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pat_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  pat_pkg::state_t                     state;
  pat_pkg::state_t                     state_next;

  logic [pat_pkg::PAGE_SIZE_W-1:0]     page_size;
  logic [pat_pkg::PAGE_COUNT_W-1:0]    page_count;

  logic [pat_pkg::INDEX_W-1:0]         in_index;
  logic [pat_pkg::FRAME_W-1:0]         in_frame;
  logic [pat_pkg::ADDR_W-1:0]          in_addr;
  logic                                in_op;
  logic                                accept;
  logic                                out_free;

  logic                                div_start;
  pat_pkg::div_stat_t                  div_stat;
  logic [pat_pkg::ADDR_W-1:0]          div_quot;
  logic [pat_pkg::PAGE_SIZE_W-1:0]     div_rem;

  logic                                ram_we;
  logic [pat_pkg::FRAME_W-1:0]         ram_rdata;

  logic [pat_pkg::ADDR_W-1:0]          limit;
  logic                                page_fault;
  logic                                fault;
  logic [pat_pkg::ADDR_W-1:0]          prod;

  // Payload unpacking
  assign in_index = s_tdata[pat_pkg::INDEX_W-1:0];
  assign in_frame = s_tdata[pat_pkg::INDEX_W +: pat_pkg::FRAME_W];
  assign in_addr  = s_tdata[pat_pkg::INDEX_W + pat_pkg::FRAME_W +: pat_pkg::ADDR_W];
  assign in_op    = s_tuser[0];
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  // Page count saturated to the table depth
  assign limit = (pat_pkg::ADDR_W'(page_count) > pat_pkg::ADDR_W'(TABLE_DEPTH)) ?
                 pat_pkg::ADDR_W'(TABLE_DEPTH) : pat_pkg::ADDR_W'(page_count);
  assign page_fault = (div_quot >= limit);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size  <= pat_pkg::PAGE_SIZE_W'(4096);
      page_count <= pat_pkg::PAGE_COUNT_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        pat_pkg::REG_PAGE_SIZE:  page_size  <= cfg_data;
        pat_pkg::REG_PAGE_COUNT: page_count <= cfg_data[pat_pkg::PAGE_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pat_pkg::ST_IDLE: begin
        if (accept && (in_op == pat_pkg::OP_TRANSLATE)) begin
          state_next = (page_size == '0) ? pat_pkg::ST_OUT : pat_pkg::ST_DIV;
        end
      end
      pat_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = page_fault ? pat_pkg::ST_OUT : pat_pkg::ST_READ;
        end
      end
      pat_pkg::ST_READ: state_next = pat_pkg::ST_OUT;
      pat_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = pat_pkg::ST_IDLE;
        end
      end
      default: state_next = pat_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    case (state)
      pat_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        div_start = accept && (in_op == pat_pkg::OP_TRANSLATE) && (page_size != '0);
        ram_we    = accept && (in_op == pat_pkg::OP_LOAD) &&
                    (pat_pkg::ADDR_W'(in_index) < pat_pkg::ADDR_W'(TABLE_DEPTH));
      end
      default: ;
    endcase
  end

  // Fault flag: zero page size on accept, or page beyond the limit
  always_ff @(posedge clk) begin
    if (state == pat_pkg::ST_IDLE) begin
      fault <= (page_size == '0);
    end else if ((state == pat_pkg::ST_DIV) && div_stat.done) begin
      fault <= page_fault;
    end
  end

  // Frame times page size, registered before the offset add
  always_ff @(posedge clk) begin
    if (state == pat_pkg::ST_READ) begin
      prod <= ram_rdata * page_size;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == pat_pkg::ST_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == pat_pkg::ST_OUT) && out_free) begin
      if (fault) begin
        m_tdata <= '0;
        m_tuser <= pat_pkg::STATUS_FAULT;
      end else begin
        m_tdata <= prod + pat_pkg::ADDR_W'(div_rem);
        m_tuser <= pat_pkg::STATUS_OK;
      end
    end
  end

  // Divider
  pat_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (in_addr),
    .divisor   (page_size),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Frame table; read address follows the quotient, written on loads
  pat_ram #(
    .WIDTH (pat_pkg::FRAME_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_index)),
    .wdata (in_frame),
    .raddr (div_quot[AW-1:0]),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

/* src/pat_checker.sv */
// ----------------------------------------------------------------------------
// pat_checker: port-level checks for the paged address translator
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic [0:0]                     s_tuser,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [pat_pkg::M_TDATA_W-1:0]  m_tdata,
  input wire logic [0:0]                     m_tuser
);

  // Stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("response changed while stalled");

  // A fault response carries a zero address
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == pat_pkg::STATUS_FAULT) |-> (m_tdata == '0))
    else $error("fault response with nonzero address");

  // No response right out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("response valid after reset");

  // A translate request occupies the block
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == pat_pkg::OP_TRANSLATE) |=> !s_tready)
    else $error("request accepted during translation");

endmodule

bind paged_address_translation pat_checker u_pat_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

/* verif/pat_translation_checker.sv */
// ----------------------------------------------------------------------------
// pat_translation_checker: response checker for the paged address translator
// Watches the request, response and configuration ports, keeps its own copy
// of the page table and registers, predicts every translate response and
// compares the responses in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_translation_checker #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  input  wire logic                            s_tready,
  // s_tdata: entry_index[5:0], frame_number[21:6], logical_address[53:22]
  input  wire logic [pat_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: op[0]
  input  wire logic [0:0]                      s_tuser,
  input  wire logic                            m_tvalid,
  input  wire logic                            m_tready,
  // m_tdata: physical_address[31:0]
  input  wire logic [pat_pkg::M_TDATA_W-1:0]   m_tdata,
  // m_tuser: status[0]
  input  wire logic [0:0]                      m_tuser,
  input  wire logic                            cfg_we,
  input  wire logic [pat_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pat_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                   errors,
  output int                                   outstanding
);

  typedef struct packed {
    logic [pat_pkg::ADDR_W-1:0] paddr;
    logic                       status;
  } xlate_result_t;

  // Shadow of the translator state
  logic [pat_pkg::PAGE_SIZE_W-1:0]  page_size;
  logic [pat_pkg::PAGE_COUNT_W-1:0] page_count;
  logic [pat_pkg::FRAME_W-1:0]      frame_table [TABLE_DEPTH];

  xlate_result_t expected_xlates [$];

  // Expected response for one logical address under the current settings
  function automatic xlate_result_t predict_translation(
    logic [pat_pkg::ADDR_W-1:0] laddr);
    xlate_result_t              res;
    logic [pat_pkg::ADDR_W-1:0] page;
    logic [pat_pkg::ADDR_W-1:0] offset;
    int unsigned                limit;
    limit = (page_count > TABLE_DEPTH) ? TABLE_DEPTH : page_count;
    res.paddr  = '0;
    res.status = pat_pkg::STATUS_FAULT;
    if (page_size != 0) begin
      page   = laddr / page_size;
      offset = laddr % page_size;
      if (page < limit) begin
        res.paddr  = pat_pkg::ADDR_W'(frame_table[page] * page_size + offset);
        res.status = pat_pkg::STATUS_OK;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    xlate_result_t exp_res;
    if (rst) begin
      page_size  = 16'd4096;
      page_count = 7'd64;
      foreach (frame_table[i]) frame_table[i] = '0;
      expected_xlates.delete();
      errors      = 0;
      outstanding = 0;
    end else begin
      // Responses first: a response never belongs to a request taken this edge
      if (m_tvalid && m_tready) begin
        if (expected_xlates.size() == 0) begin
          $display("%0t: unexpected response, got addr %h status %0d",
                   $time, m_tdata, m_tuser[0]);
          errors++;
        end else begin
          exp_res = expected_xlates.pop_front();
          if (m_tdata !== exp_res.paddr) begin
            $display("%0t: physical_address mismatch, expected %h, got %h",
                     $time, exp_res.paddr, m_tdata);
            errors++;
          end
          if (m_tuser[0] !== exp_res.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, exp_res.status, m_tuser[0]);
            errors++;
          end
        end
      end

      // Requests
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == pat_pkg::OP_LOAD) begin
          if (s_tdata[5:0] < TABLE_DEPTH)
            frame_table[s_tdata[5:0]] = s_tdata[21:6];
        end else begin
          expected_xlates.push_back(predict_translation(s_tdata[53:22]));
        end
      end

      // Register writes
      if (cfg_we) begin
        if (cfg_index == pat_pkg::REG_PAGE_SIZE)
          page_size = cfg_data[pat_pkg::PAGE_SIZE_W-1:0];
        else if (cfg_index == pat_pkg::REG_PAGE_COUNT)
          page_count = cfg_data[pat_pkg::PAGE_COUNT_W-1:0];
      end

      outstanding = expected_xlates.size();
    end
  end

endmodule

`default_nettype wire

/* verif/paged_address_translation_tb.sv */
// ----------------------------------------------------------------------------
// paged_address_translation_tb: stimulus and verdict for the translator
// Loads page table entries and translates addresses under several page size
// and page count settings, with random stalls on both streams; a separate
// checker predicts and compares every response.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_address_translation_tb;

  localparam int unsigned DEPTH         = 64;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          NUM_PHASES    = 12;
  localparam int          PHASE_ITEMS   = 58;
  localparam int          QUIET_PHASE   = 10;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [pat_pkg::S_TDATA_W-1:0]   s_tdata = '0;
  logic [0:0]                      s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [pat_pkg::M_TDATA_W-1:0]   m_tdata;
  logic [0:0]                      m_tuser;
  logic                            cfg_we = 1'b0;
  logic [pat_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [pat_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int errors;
  int outstanding;

  // Stimulus-side view of settings and loaded entries
  logic [pat_pkg::PAGE_SIZE_W-1:0]  cur_page_size = 16'd4096;
  logic [pat_pkg::PAGE_COUNT_W-1:0] cur_page_count = 7'd64;
  logic [DEPTH-1:0]                 loaded = '0;
  bit                               no_idle = 1'b0;
  int                               stall_cycles = 0;
  int                               ready_left = 0;

  always #2 clk = ~clk;

  paged_address_translation #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pat_translation_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Receiver: random ready stretches and stall bursts, always ready when quiet
  always @(negedge clk) begin
    if (no_idle || rst) begin
      m_tready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      m_tready   <= 1'b0;
      ready_left <= $urandom_range(0, 18);
    end else begin
      m_tready   <= 1'b1;
      ready_left <= $urandom_range(0, 40);
    end
  end

  // Watchdog on cycles without any accepted request or response
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one request and hold it until accepted
  task automatic issue_request(logic op, logic [pat_pkg::INDEX_W-1:0] idx,
                               logic [pat_pkg::FRAME_W-1:0] frame,
                               logic [pat_pkg::ADDR_W-1:0] laddr);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, laddr, frame, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic issue_load(logic [pat_pkg::INDEX_W-1:0] idx,
                            logic [pat_pkg::FRAME_W-1:0] frame);
    issue_request(pat_pkg::OP_LOAD, idx, frame, $urandom());
    loaded[idx] = 1'b1;
  endtask

  // Translate; an in-range page that was never loaded gets a load first
  task automatic issue_translate(logic [pat_pkg::ADDR_W-1:0] laddr);
    logic [pat_pkg::ADDR_W-1:0] page;
    int unsigned                limit;
    limit = (cur_page_count > DEPTH) ? DEPTH : cur_page_count;
    if (cur_page_size != 0) begin
      page = laddr / cur_page_size;
      if (page < limit && !loaded[page])
        issue_load(pat_pkg::INDEX_W'(page), pat_pkg::FRAME_W'($urandom()));
    end
    issue_request(pat_pkg::OP_TRANSLATE, pat_pkg::INDEX_W'($urandom()),
                  pat_pkg::FRAME_W'($urandom()), laddr);
  endtask

  // Random sender idle burst
  task automatic sender_pause();
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drain the block before a register write
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(pat_pkg::reg_index_t idx,
                           logic [pat_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == pat_pkg::REG_PAGE_SIZE)
      cur_page_size = value[pat_pkg::PAGE_SIZE_W-1:0];
    else
      cur_page_count = value[pat_pkg::PAGE_COUNT_W-1:0];
  endtask

  task automatic configure(logic [pat_pkg::CFG_DATA_W-1:0] psize,
                           logic [pat_pkg::CFG_DATA_W-1:0] pcount);
    settle();
    write_reg(pat_pkg::REG_PAGE_SIZE, psize);
    write_reg(pat_pkg::REG_PAGE_COUNT, pcount);
  endtask

  function automatic logic [pat_pkg::CFG_DATA_W-1:0] pick_page_size();
    case ($urandom_range(0, 9))
      0: return 16'd1;
      1: return 16'd2;
      2: return 16'd3;
      3: return 16'd7;
      4: return 16'd100;
      5: return 16'd4096;
      6: return 16'd65535;
      default: return pat_pkg::CFG_DATA_W'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [pat_pkg::CFG_DATA_W-1:0] pick_page_count();
    case ($urandom_range(0, 15))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd64;
      3: return 16'd127;
      4: return pat_pkg::CFG_DATA_W'($urandom_range(65, 127));
      default: return pat_pkg::CFG_DATA_W'($urandom_range(1, 64));
    endcase
  endfunction

  // One random item: mostly loads and in-range translates, some raw addresses
  task automatic random_item();
    int unsigned                pick;
    int unsigned                limit;
    logic [pat_pkg::ADDR_W-1:0] page;
    logic [pat_pkg::ADDR_W-1:0] offset;
    limit = (cur_page_count > DEPTH) ? DEPTH : cur_page_count;
    pick  = $urandom_range(0, 99);
    if (pick < 30) begin
      issue_load(pat_pkg::INDEX_W'($urandom()), pat_pkg::FRAME_W'($urandom()));
    end else if (pick < 85 && limit != 0 && cur_page_size != 0) begin
      page   = $urandom_range(0, limit - 1);
      offset = $urandom_range(0, cur_page_size - 1);
      issue_translate(page * cur_page_size + offset);
    end else begin
      issue_translate($urandom());
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed: default settings, table extremes and the fault boundary
    issue_load(6'd0, 16'h0000);
    issue_load(6'd63, 16'hFFFF);
    issue_load(6'd1, 16'h5A5A);
    issue_translate(32'd0);
    issue_translate(32'd1 * 4096 + 32'd17);
    issue_translate(32'd63 * 4096 + 32'd4095);
    issue_translate(32'd64 * 4096);
    issue_translate(32'hFFFF_FFFF);

    // Largest page size, page count above the table depth (saturates)
    configure(16'd65535, 16'd127);
    issue_translate(32'd63 * 65535 + 32'd65534);
    issue_translate(32'd64 * 65535);
    issue_translate(32'hFFFF_FFFF);

    // Smallest nonzero page size and page count
    configure(16'd1, 16'd1);
    issue_translate(32'd0);
    issue_translate(32'd1);

    // Zero page size faults everything
    configure(16'd0, 16'd64);
    issue_translate(32'd0);
    issue_translate(32'd5);

    // Zero page count faults everything
    configure(16'd3, 16'd0);
    issue_translate(32'd0);
    issue_translate(32'd2);

    // Page count written with upper bits set; only the low seven count
    configure(16'd3, 16'hFF81);
    issue_translate(32'd2);
    issue_translate(32'd3);

    // Random phases under changing settings, the last ones without idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0)
        configure(16'd4096, 16'd64);
      else
        configure(pick_page_size(), pick_page_count());
      if (ph >= QUIET_PHASE)
        no_idle = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item();
        sender_pause();
      end
    end

    // Wait for the last responses, then give the verdict
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
src/pat_pkg.sv
src/pat_ram.sv
src/pat_div.sv
src/paged_address_translation.sv
src/pat_checker.sv
verif/pat_translation_checker.sv
verif/paged_address_translation_tb.sv
